// File: rtl/lvo_pkg.sv
// ----------------------------------------------------------------------------
// lvo_pkg: shared types and constants of the 3D label outline core
// Sizes, register indexes, configuration and control bundles.
// ----------------------------------------------------------------------------
package lvo_pkg;

    localparam int MAX_W   = 256;
    localparam int MAX_H   = 256;
    localparam int MAX_D   = 256;
    localparam int LABEL_W = 16;

    localparam int DIM_W  = $clog2(MAX_W + 1);              // holds a size up to MAX
    localparam int CRD_W  = $clog2(MAX_W);                  // holds a coordinate
    localparam int WH_W   = $clog2(MAX_W * MAX_H + 1);
    localparam int DLY_W  = $clog2(MAX_W * MAX_H + MAX_W + 2);
    localparam int POS_W  = $clog2(MAX_W * MAX_H * MAX_D + MAX_W * MAX_H + MAX_W + 2);

    localparam int LINE_DEPTH  = 2 * MAX_W;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int PLANE_DEPTH = 2 * MAX_W * MAX_H;
    localparam int PLANE_AW    = $clog2(PLANE_DEPTH);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 3'd4;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);
    localparam logic [DIM_W-1:0] MIN_W_DIM = DIM_W'(3);
    localparam logic [DIM_W-1:0] MIN_HD_DIM = DIM_W'(1);
    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_W);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_H);
    localparam logic [DIM_W-1:0] MAX_D_DIM = DIM_W'(MAX_D);

    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    typedef logic [LABEL_W-1:0] t_label;
    typedef t_label [2:0][2:0][2:0] t_win;   // [plane][line][column], 0 = newest

    typedef struct packed {
        t_label             bg;
        logic               conn26;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [DIM_W-1:0]   d;
        logic [WH_W-1:0]    wh;
        logic [POS_W-1:0]   total;
        logic [DLY_W-1:0]   delay;
    } t_cfg;

    typedef struct packed {
        logic emit;
        logic last;
        logic x_lo;
        logic x_hi;
        logic y_lo;
        logic y_hi;
        logic z_lo;
        logic z_hi;
    } t_ctl;

endpackage

// File: rtl/lvo_ram.sv
// ----------------------------------------------------------------------------
// lvo_ram: generic RAM, one write port, two registered read ports
// Read data is the old content when read and write hit the same address.
// ----------------------------------------------------------------------------
module lvo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: rtl/lvo_cfg.sv
// ----------------------------------------------------------------------------
// lvo_cfg: configuration registers and derived volume sizes
// Clamps sizes, forms plane size, voxel count and window delay in register
// stages and holds o_busy while they settle.
// ----------------------------------------------------------------------------
module lvo_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [lvo_pkg::CFG_IDX_W-1:0]     i_index,
    input  logic [lvo_pkg::CFG_DATA_W-1:0]    i_data,
    output lvo_pkg::t_cfg                     o_cfg,
    output logic                              o_busy
);

    lvo_pkg::t_label                 r_bg;
    logic                            r_conn;
    logic [lvo_pkg::DIM_W-1:0]       r_raw_w, r_raw_h, r_raw_d;
    logic [lvo_pkg::DIM_W-1:0]       r_w, r_h, r_d;
    logic [lvo_pkg::WH_W-1:0]        r_wh;
    logic [lvo_pkg::POS_W-1:0]       r_total;
    logic [lvo_pkg::DLY_W-1:0]       r_delay;
    logic [1:0]                      r_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg     <= '0;
            r_conn   <= 1'b1;
            r_raw_w  <= lvo_pkg::DIM_RESET;
            r_raw_h  <= lvo_pkg::DIM_RESET;
            r_raw_d  <= lvo_pkg::DIM_RESET;
            r_settle <= lvo_pkg::SETTLE_CYCLES;
        end else begin
            if (i_wr) begin
                r_settle <= lvo_pkg::SETTLE_CYCLES;
                unique case (i_index)
                    lvo_pkg::REG_BACKGROUND: r_bg    <= i_data[lvo_pkg::LABEL_W-1:0];
                    lvo_pkg::REG_CONNECT:    r_conn  <= i_data[0];
                    lvo_pkg::REG_WIDTH:      r_raw_w <= i_data[lvo_pkg::DIM_W-1:0];
                    lvo_pkg::REG_HEIGHT:     r_raw_h <= i_data[lvo_pkg::DIM_W-1:0];
                    lvo_pkg::REG_DEPTH:      r_raw_d <= i_data[lvo_pkg::DIM_W-1:0];
                    default: ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    // derived sizes, at most one multiply per register stage
    always_ff @(posedge i_clk) begin
        r_w <= (r_raw_w < lvo_pkg::MIN_W_DIM) ? lvo_pkg::MIN_W_DIM :
               (r_raw_w > lvo_pkg::MAX_W_DIM) ? lvo_pkg::MAX_W_DIM : r_raw_w;
        r_h <= (r_raw_h < lvo_pkg::MIN_HD_DIM) ? lvo_pkg::MIN_HD_DIM :
               (r_raw_h > lvo_pkg::MAX_H_DIM) ? lvo_pkg::MAX_H_DIM : r_raw_h;
        r_d <= (r_raw_d < lvo_pkg::MIN_HD_DIM) ? lvo_pkg::MIN_HD_DIM :
               (r_raw_d > lvo_pkg::MAX_D_DIM) ? lvo_pkg::MAX_D_DIM : r_raw_d;
        r_wh    <= lvo_pkg::WH_W'(r_w) * lvo_pkg::WH_W'(r_h);
        r_total <= lvo_pkg::POS_W'(r_wh) * lvo_pkg::POS_W'(r_d);
        r_delay <= lvo_pkg::DLY_W'(r_wh) + lvo_pkg::DLY_W'(r_w) + lvo_pkg::DLY_W'(1);
    end

    assign o_cfg.bg     = r_bg;
    assign o_cfg.conn26 = r_conn;
    assign o_cfg.w      = r_w;
    assign o_cfg.h      = r_h;
    assign o_cfg.d      = r_d;
    assign o_cfg.wh     = r_wh;
    assign o_cfg.total  = r_total;
    assign o_cfg.delay  = r_delay;
    assign o_busy       = (r_settle != 2'd0);

endmodule

// File: rtl/lvo_seq.sv
// ----------------------------------------------------------------------------
// lvo_seq: input position and center coordinate sequencer
// Decides per accepted item whether it is stored, whether it emits, and the
// border flags of the voxel that leaves the window.
// ----------------------------------------------------------------------------
module lvo_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lvo_pkg::t_cfg        i_cfg,
    input  logic                 i_accept,
    input  lvo_pkg::t_label      i_label,
    input  logic                 i_drain,
    output logic                 o_act,
    output lvo_pkg::t_label      o_wdata,
    output lvo_pkg::t_ctl        o_ctl
);

    logic [lvo_pkg::POS_W-1:0] r_pos;
    logic [lvo_pkg::CRD_W-1:0] r_cx, r_cy, r_cz;
    logic [lvo_pkg::DIM_W-1:0] cx_inc, cy_inc, cz_inc;
    logic                      in_vol;
    logic                      emit;
    logic                      last;

    always_comb begin
        cx_inc  = lvo_pkg::DIM_W'(r_cx) + lvo_pkg::DIM_W'(1);
        cy_inc  = lvo_pkg::DIM_W'(r_cy) + lvo_pkg::DIM_W'(1);
        cz_inc  = lvo_pkg::DIM_W'(r_cz) + lvo_pkg::DIM_W'(1);
        in_vol  = r_pos < i_cfg.total;
        emit    = r_pos >= lvo_pkg::POS_W'(i_cfg.delay);
        last    = (cx_inc >= i_cfg.w) && (cy_inc >= i_cfg.h) && (cz_inc >= i_cfg.d);
        // a drain inside the volume does nothing at all
        o_act   = i_accept && !(i_drain && in_vol);
        o_wdata = in_vol ? i_label : '0;
        o_ctl.emit = emit;
        o_ctl.last = last;
        o_ctl.x_lo = (r_cx != '0);
        o_ctl.x_hi = (cx_inc < i_cfg.w);
        o_ctl.y_lo = (r_cy != '0);
        o_ctl.y_hi = (cy_inc < i_cfg.h);
        o_ctl.z_lo = (r_cz != '0);
        o_ctl.z_hi = (cz_inc < i_cfg.d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
        end else if (o_act) begin
            if (emit && last) begin
                r_pos <= '0;
                r_cx  <= '0;
                r_cy  <= '0;
                r_cz  <= '0;
            end else begin
                r_pos <= r_pos + lvo_pkg::POS_W'(1);
                if (emit) begin
                    if (cx_inc >= i_cfg.w) begin
                        r_cx <= '0;
                        if (cy_inc >= i_cfg.h) begin
                            r_cy <= '0;
                            r_cz <= (cz_inc >= i_cfg.d) ? '0 : r_cz + lvo_pkg::CRD_W'(1);
                        end else begin
                            r_cy <= r_cy + lvo_pkg::CRD_W'(1);
                        end
                    end else begin
                        r_cx <= r_cx + lvo_pkg::CRD_W'(1);
                    end
                end
            end
        end
    end

endmodule

// File: rtl/lvo_window.sv
// ----------------------------------------------------------------------------
// lvo_window: plane and line delay buffers forming the 3x3x3 window
// One plane RAM gives the two earlier planes, three line RAMs the two earlier
// lines of each plane, registers the two earlier columns.
// ----------------------------------------------------------------------------
module lvo_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lvo_pkg::t_cfg        i_cfg,
    input  logic                 i_clr,
    input  logic                 i_en,
    input  logic                 i_act,
    input  lvo_pkg::t_label      i_wdata,
    input  lvo_pkg::t_ctl        i_ctl,
    output logic                 o_valid,
    output lvo_pkg::t_ctl        o_ctl,
    output lvo_pkg::t_win        o_win
);

    logic [lvo_pkg::PLANE_AW-1:0] r_pp;
    logic [lvo_pkg::PLANE_AW-1:0] pp_b;
    logic [lvo_pkg::PLANE_AW:0]   pp_inc;
    logic [lvo_pkg::LINE_AW-1:0]  r_lp;
    logic [lvo_pkg::LINE_AW-1:0]  lp_b;
    logic [lvo_pkg::LINE_AW:0]    lp_inc;

    logic                         r_v1, r_v2;
    lvo_pkg::t_ctl                r_ctl1, r_ctl2;
    lvo_pkg::t_label              r_s0;
    lvo_pkg::t_label [2:0]        stream;       // per plane, at stage 1
    lvo_pkg::t_label [2:0]        r_row0;       // per plane, at stage 2
    lvo_pkg::t_label [2:0]        line_far;     // two lines back
    lvo_pkg::t_label [2:0]        line_near;    // one line back
    lvo_pkg::t_label [2:0][2:0]   row;
    lvo_pkg::t_label [2:0][2:0]   r_col1, r_col2;

    // plane pointer wraps at two planes; read at it gives two planes back
    assign pp_inc = {1'b0, r_pp} + (lvo_pkg::PLANE_AW+1)'(1);
    assign pp_b   = (r_pp >= lvo_pkg::PLANE_AW'(i_cfg.wh)) ?
                    r_pp - lvo_pkg::PLANE_AW'(i_cfg.wh) :
                    r_pp + lvo_pkg::PLANE_AW'(i_cfg.wh);
    assign lp_inc = {1'b0, r_lp} + (lvo_pkg::LINE_AW+1)'(1);
    assign lp_b   = (r_lp >= lvo_pkg::LINE_AW'(i_cfg.w)) ?
                    r_lp - lvo_pkg::LINE_AW'(i_cfg.w) :
                    r_lp + lvo_pkg::LINE_AW'(i_cfg.w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp <= '0;
            r_lp <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (i_en) begin
                r_v1 <= i_act;
                r_v2 <= r_v1;
            end
            // new sizes: restart both rings inside their new length
            if (i_clr) begin
                r_pp <= '0;
                r_lp <= '0;
            end else if (i_en) begin
                if (i_act) begin
                    r_pp <= (pp_inc == (lvo_pkg::PLANE_AW+1)'({i_cfg.wh, 1'b0})) ?
                            '0 : pp_inc[lvo_pkg::PLANE_AW-1:0];
                end
                if (r_v1) begin
                    r_lp <= (lp_inc == (lvo_pkg::LINE_AW+1)'({i_cfg.w, 1'b0})) ?
                            '0 : lp_inc[lvo_pkg::LINE_AW-1:0];
                end
            end
        end
    end

    lvo_ram #(
        .WIDTH (lvo_pkg::LABEL_W),
        .DEPTH (lvo_pkg::PLANE_DEPTH)
    ) u_plane (
        .i_clk     (i_clk),
        .i_we      (i_en && i_act),
        .i_waddr   (r_pp),
        .i_wdata   (i_wdata),
        .i_re      (i_en),
        .i_raddr_a (r_pp),
        .i_raddr_b (pp_b),
        .o_rdata_a (stream[2]),
        .o_rdata_b (stream[1])
    );

    assign stream[0] = r_s0;

    for (genvar a = 0; a < 3; a++) begin : g_line
        lvo_ram #(
            .WIDTH (lvo_pkg::LABEL_W),
            .DEPTH (lvo_pkg::LINE_DEPTH)
        ) u_line (
            .i_clk     (i_clk),
            .i_we      (i_en && r_v1),
            .i_waddr   (r_lp),
            .i_wdata   (stream[a]),
            .i_re      (i_en),
            .i_raddr_a (r_lp),
            .i_raddr_b (lp_b),
            .o_rdata_a (line_far[a]),
            .o_rdata_b (line_near[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0   <= i_wdata;
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_row0 <= stream;
            if (r_v2) begin
                r_col1 <= row;
                r_col2 <= r_col1;
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            row[a][0] = r_row0[a];
            row[a][1] = line_near[a];
            row[a][2] = line_far[a];
            for (int b = 0; b < 3; b++) begin
                o_win[a][b][0] = row[a][b];
                o_win[a][b][1] = r_col1[a][b];
                o_win[a][b][2] = r_col2[a][b];
            end
        end
    end

    assign o_valid = r_v2;
    assign o_ctl   = r_ctl2;

endmodule

// File: rtl/label_volume_outline_3d_core.sv
// ----------------------------------------------------------------------------
// label_volume_outline_3d_core: outline of a 3D label volume on a stream
// Keeps a voxel's label where a neighbor inside the volume differs, else
// writes the background label; 6 or 26 neighbors.
// ----------------------------------------------------------------------------
// Voxels enter in raster order (x fastest, then y, then z), one item per
// clock when the output side keeps up. The result for a voxel leaves once
// one plane, one line and one more voxel have entered behind it, so after
// the last voxel the user sends drain items (tuser = 1) to flush the tail;
// a drain sent inside the volume is swallowed. The result of the final
// voxel carries tlast, and the next item starts a new volume. Inside the
// core an item passes three register stages, the first loaded at the
// accepting edge: the plane RAM read, the line RAM reads, then the neighbor
// compare into the output register. The window holds two planes in one
// plane RAM (2 x 256 x 256 labels, read at two addresses) and two lines
// per plane in three line RAMs. Buffers are not cleared; voxels outside
// the volume are masked by coordinate. After a configuration write the
// input is held not ready while the clamped sizes, voxel count and window
// delay settle, and the buffer pointers restart.
// ----------------------------------------------------------------------------
module label_volume_outline_3d_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,   // [15:0] voxel_label
    input  logic                              s_axis_tuser,   // [0] drain
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // [15:0] outline_label
    output logic                              m_axis_tlast,   // last_voxel
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lvo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lvo_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    lvo_pkg::t_cfg   cfg;
    logic            cfg_busy;
    logic            en;
    logic            accept;
    logic            act;
    lvo_pkg::t_label wdata;
    lvo_pkg::t_ctl   ctl_s0;
    logic            win_valid;
    lvo_pkg::t_ctl   win_ctl;
    lvo_pkg::t_win   win;
    lvo_pkg::t_label center;
    logic            edge_hit;
    lvo_pkg::t_label result;

    logic            r_m_valid;
    lvo_pkg::t_label r_m_data;
    logic            r_m_last;

    // whole pipeline moves together whenever the output register can load
    assign en            = !r_m_valid || m_axis_tready;
    assign s_axis_tready = en && !cfg_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    lvo_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg),
        .o_busy  (cfg_busy)
    );

    lvo_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_label  (s_axis_tdata),
        .i_drain  (s_axis_tuser),
        .o_act    (act),
        .o_wdata  (wdata),
        .o_ctl    (ctl_s0)
    );

    lvo_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_clr   (cfg_busy),
        .i_en    (en),
        .i_act   (act),
        .i_wdata (wdata),
        .i_ctl   (ctl_s0),
        .o_valid (win_valid),
        .o_ctl   (win_ctl),
        .o_win   (win)
    );

    // Window index 0 is the newest plane/line/column, i.e. the +1 neighbor;
    // index 2 is the -1 neighbor; index 1 on all three axes is the center.
    always_comb begin
        logic ok_z, ok_y, ok_x;
        logic [1:0] hops;
        center   = win[1][1][1];
        edge_hit = 1'b0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                for (int c = 0; c < 3; c++) begin
                    ok_z = (a == 0) ? win_ctl.z_hi : (a == 2) ? win_ctl.z_lo : 1'b1;
                    ok_y = (b == 0) ? win_ctl.y_hi : (b == 2) ? win_ctl.y_lo : 1'b1;
                    ok_x = (c == 0) ? win_ctl.x_hi : (c == 2) ? win_ctl.x_lo : 1'b1;
                    hops = 2'((a != 1)) + 2'((b != 1)) + 2'((c != 1));
                    if ((hops != 2'd0) && (cfg.conn26 || hops == 2'd1)
                        && ok_z && ok_y && ok_x && (win[a][b][c] != center)) begin
                        edge_hit = 1'b1;
                    end
                end
            end
        end
        result = (center != cfg.bg && edge_hit) ? center : cfg.bg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= win_valid && win_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_data <= result;
            r_m_last <= win_ctl.last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

// File: tb/label_volume_outline_3d_core_test.sv
// ----------------------------------------------------------------------------
// label_volume_outline_3d_core_test: self-checking bench of the outline core
// Streams label volumes under many size, background and connectivity settings,
// predicts each outline item and compares it with the core's output stream.
// ----------------------------------------------------------------------------
module label_volume_outline_3d_core_test;

    localparam int HIST_LEN   = 2 * (lvo_pkg::MAX_W * lvo_pkg::MAX_H + lvo_pkg::MAX_W + 1) + 1;
    localparam int CYCLE_CAP  = 900000;
    localparam int ITEM_GOAL  = 1200;

    // ------------------------------------------------------------------------
    // Outline predictor and store of expected outline items
    // ------------------------------------------------------------------------
    class outline_scoreboard;
        typedef struct {
            bit [15:0] label;
            bit        last;
        } t_outline;

        bit [15:0]   voxels [HIST_LEN];   // ring of recent labels, zero at start
        int unsigned pos;
        int          cx, cy, cz;
        bit [15:0]   bg;
        bit          conn26;
        bit [8:0]    wr, hr, dr;
        t_outline    expected_outlines[$];
        int          errors;

        function new();
            pos = 0; cx = 0; cy = 0; cz = 0;
            bg = '0; conn26 = 1'b1;
            wr = 9'd256; hr = 9'd256; dr = 9'd256;
            errors = 0;
        endfunction

        function int dim_w();
            return (wr < 3) ? 3 : ((wr > lvo_pkg::MAX_W) ? lvo_pkg::MAX_W : int'(wr));
        endfunction
        function int dim_h();
            return (hr < 1) ? 1 : ((hr > lvo_pkg::MAX_H) ? lvo_pkg::MAX_H : int'(hr));
        endfunction
        function int dim_d();
            return (dr < 1) ? 1 : ((dr > lvo_pkg::MAX_D) ? lvo_pkg::MAX_D : int'(dr));
        endfunction

        function void set_reg(logic [lvo_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                lvo_pkg::REG_BACKGROUND: bg = data;
                lvo_pkg::REG_CONNECT:    conn26 = data[0];
                lvo_pkg::REG_WIDTH:      wr = data[8:0];
                lvo_pkg::REG_HEIGHT:     hr = data[8:0];
                lvo_pkg::REG_DEPTH:      dr = data[8:0];
                default: ;
            endcase
        endfunction

        // one accepted input item; pushes the outline item it causes, if any
        function void note_voxel(bit [15:0] label, bit drain);
            int          w, h, d, dly, rel;
            int unsigned total, base, idx;
            bit [15:0]   centre;
            bit          on_edge, last;
            t_outline    o;
            w = dim_w(); h = dim_h(); d = dim_d();
            total = w * h * d;
            dly = w * h + w + 1;
            if (pos < total) begin
                if (drain) return;          // swallowed inside the volume
                voxels[pos % HIST_LEN] = label;
            end else begin
                voxels[pos % HIST_LEN] = '0; // tail item, label ignored
            end
            if (pos < dly) begin
                pos++;
                return;
            end
            base = pos % HIST_LEN;
            centre = voxels[(base + HIST_LEN - dly) % HIST_LEN];
            on_edge = 1'b0;
            if (centre != bg) begin
                for (int dz = -1; dz <= 1; dz++)
                    for (int dy = -1; dy <= 1; dy++)
                        for (int dx = -1; dx <= 1; dx++) begin
                            int m;
                            m = (dx != 0) + (dy != 0) + (dz != 0);
                            if (m == 0 || (!conn26 && m != 1)) continue;
                            if (cx + dx < 0 || cy + dy < 0 || cz + dz < 0) continue;
                            if (cx + dx >= w || cy + dy >= h || cz + dz >= d) continue;
                            rel = dly + dz * w * h + dy * w + dx;
                            idx = (base + HIST_LEN - 2 * dly + rel) % HIST_LEN;
                            if (voxels[idx] != centre) on_edge = 1'b1;
                        end
            end
            last = (cx >= w - 1) && (cy >= h - 1) && (cz >= d - 1);
            o.label = on_edge ? centre : bg;
            o.last  = last;
            expected_outlines.push_back(o);
            if (last) begin
                cx = 0; cy = 0; cz = 0; pos = 0;
            end else begin
                pos++;
                cx++;
                if (cx >= w) begin
                    cx = 0; cy++;
                    if (cy >= h) begin
                        cy = 0; cz++;
                        if (cz >= d) cz = 0;
                    end
                end
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_outline(bit [15:0] label, bit last);
            t_outline o;
            if (expected_outlines.size() == 0) begin
                report($sformatf("unexpected outline item label=%h last=%b", label, last));
                return;
            end
            o = expected_outlines.pop_front();
            if (label !== o.label)
                report($sformatf("outline label %h, expected %h", label, o.label));
            if (last !== o.last)
                report($sformatf("last flag %b, expected %b", last, o.last));
        endtask

        function int pending();
            return expected_outlines.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata = '0;     // [15:0] voxel_label
    logic                           s_tuser = 1'b0;   // [0] drain
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [15:0]                    m_tdata;          // [15:0] outline_label
    logic                           m_tlast;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [lvo_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [15:0]                    cfg_data = '0;

    label_volume_outline_3d_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    outline_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          items_sent    = 0;
    int          outlines_seen = 0;
    int          cycles        = 0;
    int          hold_left     = 0;
    bit          hold_done     = 1'b0;
    bit [15:0]   palette [3];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output side: random stalls plus one long hold-off so the window fills
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (!hold_done && outlines_seen >= 200) begin
            hold_done = 1'b1;
            hold_left = 3000;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            outlines_seen++;
            sb.check_outline(m_tdata, m_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers: called just after a falling edge, return just after one
    // ------------------------------------------------------------------------
    task send_item(bit [15:0] label, bit drain);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = label;
        s_tuser  = drain;
        do @(posedge i_clk); while (!s_tready);
        sb.note_voxel(label, drain);
        items_sent++;
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task write_reg(logic [lvo_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge i_clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // every expected item in, then a wait for ignored items in flight
    task wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function bit [15:0] pick_label();
        case ($urandom_range(0, 3))
            0:       return sb.bg;
            3:       return 16'($urandom);
            default: return palette[$urandom_range(0, 2)];
        endcase
    endfunction

    // one volume with random contents, stray drains inside, mixed tail
    task send_volume();
        int total, dly;
        total = sb.dim_w() * sb.dim_h() * sb.dim_d();
        dly   = sb.dim_w() * sb.dim_h() + sb.dim_w() + 1;
        for (int p = 0; p < total; p++) begin
            if ($urandom_range(0, 19) == 0) send_item(16'($urandom), 1'b1);
            send_item(pick_label(), 1'b0);
        end
        // a plain voxel past the end counts as a drain too
        for (int t = 0; t < dly; t++) send_item(16'($urandom), 1'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        bit [15:0] wv, hv, dv, bgv;
        int        phase;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: 3x2x2 volume, six neighbors, full-range labels
        write_reg(lvo_pkg::REG_BACKGROUND, 16'h0000);
        write_reg(lvo_pkg::REG_CONNECT, 16'h0000);
        write_reg(lvo_pkg::REG_WIDTH, 16'd3);
        write_reg(lvo_pkg::REG_HEIGHT, 16'd2);
        write_reg(lvo_pkg::REG_DEPTH, 16'd2);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b1);   // stray drain mid-volume
        send_item(16'h8000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h5555, 1'b0);
        send_item(16'hAAAA, 1'b0);
        send_item(16'h5555, 1'b0);
        for (int t = 0; t < 10; t++) send_item(16'h1234, t[0]);
        wait_idle();

        // extremes first, then random settings until enough items have gone
        phase = 0;
        while (phase < 6 || items_sent < ITEM_GOAL) begin
            case (phase % 3)
                0:       begin send_idle_pct = 26; recv_idle_pct = 84; end
                1:       begin send_idle_pct = 84; recv_idle_pct = 26; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            bgv = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
            case (phase)
                0:       begin wv = 16'hFFFF; hv = 16'd1;   dv = 16'd1;   end
                1:       begin wv = 16'd0;    hv = 16'd40;  dv = 16'd1;   end
                2:       begin wv = 16'd2;    hv = 16'd0;   dv = 16'd64;  end
                3:       begin wv = 16'd3;    hv = 16'd1;   dv = 16'd1;   end
                4:       begin wv = 16'd4;    hv = 16'd3;   dv = 16'd3;   bgv = 16'hFFFF; end
                default: begin
                    wv = {7'($urandom), 9'($urandom_range(0, 9))};
                    hv = {7'($urandom), 9'($urandom_range(0, 5))};
                    dv = {7'($urandom), 9'($urandom_range(0, 5))};
                end
            endcase
            write_reg(lvo_pkg::REG_BACKGROUND, bgv);
            write_reg(lvo_pkg::REG_CONNECT, 16'($urandom));
            write_reg(lvo_pkg::REG_WIDTH, wv);
            write_reg(lvo_pkg::REG_HEIGHT, hv);
            write_reg(lvo_pkg::REG_DEPTH, dv);
            palette[0] = 16'($urandom);
            palette[1] = bgv ^ 16'h0001;
            palette[2] = bgv ^ 16'h8000;
            // large extremes once, small volumes once or twice
            repeat ((phase < 3) ? 1 : $urandom_range(1, 2)) send_volume();
            wait_idle();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: label_volume_outline_3d_core.f
rtl/lvo_pkg.sv
rtl/lvo_ram.sv
rtl/lvo_cfg.sv
rtl/lvo_seq.sv
rtl/lvo_window.sv
rtl/label_volume_outline_3d_core.sv
tb/label_volume_outline_3d_core_test.sv
